// ===== sv/smac_pkg.sv =====
// ---------------------------------------------------------------------------
// smac_pkg: shared types and constants for the sliding median alert block
// Field widths of the sample and result requests, and the control word that
// the top level broadcasts to every cell of the sorted window chain.
// ---------------------------------------------------------------------------
`default_nettype none

package smac_pkg;

  localparam int SAMPLE_W = 8;
  localparam int TOTAL_W  = 16;
  localparam int CFG_W    = 6;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Broadcast to all cells in the same cycle.
  typedef struct packed {
    logic                load;    // a sample request is taken this cycle
    logic                clear;   // drop every entry (reset or length write)
    logic                flush;   // new series: treat current entries as gone
    logic                del_en;  // window full: remove the oldest entry
    logic [SAMPLE_W-1:0] sample;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/smac_in_if.sv =====
// ---------------------------------------------------------------------------
// smac_in_if: sample request channel
// Valid/ready channel carrying one sample and the new-series flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface smac_in_if;
  logic                          valid;
  logic                          ready;
  logic [smac_pkg::SAMPLE_W-1:0] sample;
  logic                          new_series;

  modport source (output valid, output sample, output new_series, input ready);
  modport sink   (input valid, input sample, input new_series, output ready);
endinterface

`default_nettype wire

// ===== sv/smac_out_if.sv =====
// ---------------------------------------------------------------------------
// smac_out_if: alert result channel
// Valid/ready channel carrying the alert flag and the running alert total.
// ---------------------------------------------------------------------------
`default_nettype none

interface smac_out_if;
  logic                         valid;
  logic                         ready;
  logic                         alert;
  logic [smac_pkg::TOTAL_W-1:0] alert_total;

  modport source (output valid, output alert, output alert_total, input ready);
  modport sink   (input valid, input alert, input alert_total, output ready);
endinterface

`default_nettype wire

// ===== sv/smac_cell.sv =====
// ---------------------------------------------------------------------------
// smac_cell: one entry of the sorted window chain
// Holds one sample and its ring slot tag. Each update first closes the gap
// left by the removed oldest entry, then opens a slot for the new sample;
// the cell takes its value from itself, its upper or lower neighbor, or the
// new sample.
// ---------------------------------------------------------------------------
`default_nettype none

module smac_cell #(
  parameter int TAG_W = 5
) (
  input  wire                           clk,
  input  wire  smac_pkg::cell_ctrl_t    ctrl,
  input  wire  [TAG_W-1:0]              old_tag,
  input  wire  [TAG_W-1:0]              new_tag,
  // raw contents of the cell above
  input  wire                           up_valid,
  input  wire  [smac_pkg::SAMPLE_W-1:0] up_value,
  input  wire  [TAG_W-1:0]              up_tag,
  // compacted contents of the cell below
  input  wire                           lo_valid,
  input  wire  [smac_pkg::SAMPLE_W-1:0] lo_value,
  input  wire  [TAG_W-1:0]              lo_tag,
  input  wire                           lo_gt,
  input  wire                           del_in,
  output logic                          valid,
  output logic [smac_pkg::SAMPLE_W-1:0] value,
  output logic [TAG_W-1:0]              tag,
  output logic                          a_valid,
  output logic [smac_pkg::SAMPLE_W-1:0] a_value,
  output logic [TAG_W-1:0]              a_tag,
  output logic                          a_gt,
  output logic                          del_out
);

  logic                          own_v;
  logic                          up_v;
  logic                          del_here;
  logic                          take_up;
  logic                          valid_next;
  logic [smac_pkg::SAMPLE_W-1:0] value_next;
  logic [TAG_W-1:0]              tag_next;

  always_comb begin
    own_v    = valid & ~ctrl.flush;
    up_v     = up_valid & ~ctrl.flush;
    del_here = ctrl.del_en & own_v & (tag == old_tag);
    take_up  = del_in | del_here;
    del_out  = take_up;

    a_valid  = take_up ? up_v     : own_v;
    a_value  = take_up ? up_value : value;
    a_tag    = take_up ? up_tag   : tag;
    // empty slots sort above every sample
    a_gt     = ~a_valid | (a_value > ctrl.sample);

    if (!a_gt) begin
      valid_next = a_valid;
      value_next = a_value;
      tag_next   = a_tag;
    end else if (!lo_gt) begin
      valid_next = 1'b1;
      value_next = ctrl.sample;
      tag_next   = new_tag;
    end else begin
      valid_next = lo_valid;
      value_next = lo_value;
      tag_next   = lo_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= value_next;
      tag   <= tag_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sliding_median_alert_top.sv =====
// ---------------------------------------------------------------------------
// sliding_median_alert_top: sliding window median threshold detector
// Keeps the last window_length samples sorted in a chain of cells and flags
// every sample that reaches twice the window median once the window is full.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      sample[7:0], new_series
//   out_ch    out  valid/ready      alert, alert_total[15:0]
//   wr_en     in   write enable     wr_data[5:0] -> window_length
//
// One sample request per cycle while in_ch.ready is high; the median lookup,
// compare and chain update all finish in the cycle the request is taken.
// The result register decouples the sides: in_ch.ready drops only while a
// result is held and out_ch.ready is low.
// Reset sets window_length to 1 and empties the window; writing the length
// also starts a new series. No result while the window fills.
// ---------------------------------------------------------------------------
`default_nettype none

module sliding_median_alert_top #(
  parameter int WINDOW_MAX = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         wr_en,
  input  wire  [smac_pkg::CFG_W-1:0]  wr_data,
  smac_in_if.sink                     in_ch,
  smac_out_if.source                  out_ch
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int TAG_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMP_W = (LEN_W > smac_pkg::CFG_W) ? LEN_W : smac_pkg::CFG_W;

  logic [smac_pkg::CFG_W-1:0]   window_length;
  logic [LEN_W-1:0]             fill_level;
  logic [TAG_W-1:0]             oldest_ptr;
  logic [smac_pkg::TOTAL_W-1:0] alert_counter;
  logic                         res_valid;
  logic                         res_alert;
  logic [smac_pkg::TOTAL_W-1:0] res_total;

  logic [CMP_W-1:0]             cfg_ext;
  logic [LEN_W-1:0]             len;
  logic [LEN_W-1:0]             fill_eff;
  logic                         full;
  logic                         accept;
  logic [TAG_W-1:0]             lo_idx;
  logic [TAG_W-1:0]             hi_idx;
  logic [smac_pkg::SAMPLE_W:0]  twice_med;
  logic                         alert;
  logic [smac_pkg::TOTAL_W-1:0] counter_next;
  logic [TAG_W-1:0]             ptr_next;
  logic [TAG_W-1:0]             new_tag;
  smac_pkg::cell_ctrl_t         ctrl;

  logic                          c_valid [WINDOW_MAX];
  logic [smac_pkg::SAMPLE_W-1:0] c_value [WINDOW_MAX];
  logic [TAG_W-1:0]              c_tag   [WINDOW_MAX];
  logic                          a_valid [WINDOW_MAX];
  logic [smac_pkg::SAMPLE_W-1:0] a_value [WINDOW_MAX];
  logic [TAG_W-1:0]              a_tag   [WINDOW_MAX];
  logic                          a_gt    [WINDOW_MAX];
  logic                          del_c   [WINDOW_MAX];

  assign accept      = in_ch.valid & in_ch.ready;
  assign in_ch.ready = ~res_valid | out_ch.ready;

  always_comb begin
    cfg_ext = CMP_W'(window_length);
    if (cfg_ext == '0) begin
      len = LEN_W'(1);
    end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(cfg_ext);
    end

    fill_eff = in_ch.new_series ? '0 : fill_level;
    full     = (fill_eff == len);

    // ranks (len+1)/2 and len/2+1, one based
    lo_idx    = TAG_W'((len - LEN_W'(1)) >> 1);
    hi_idx    = TAG_W'(len >> 1);
    twice_med = {1'b0, c_value[lo_idx]} + {1'b0, c_value[hi_idx]};
    alert     = {1'b0, in_ch.sample} >= twice_med;

    counter_next = alert_counter;
    if (alert && alert_counter != smac_pkg::TOTAL_MAX) begin
      counter_next = alert_counter + smac_pkg::TOTAL_W'(1);
    end

    if (LEN_W'(oldest_ptr) + LEN_W'(1) == len) begin
      ptr_next = '0;
    end else begin
      ptr_next = oldest_ptr + TAG_W'(1);
    end

    new_tag = full ? oldest_ptr : TAG_W'(fill_eff);

    ctrl.load   = accept;
    ctrl.clear  = rst | wr_en;
    ctrl.flush  = in_ch.new_series;
    ctrl.del_en = full;
    ctrl.sample = in_ch.sample;
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                          up_valid;
    logic [smac_pkg::SAMPLE_W-1:0] up_value;
    logic [TAG_W-1:0]              up_tag;
    logic                          lo_valid;
    logic [smac_pkg::SAMPLE_W-1:0] lo_value;
    logic [TAG_W-1:0]              lo_tag;
    logic                          lo_gt;
    logic                          del_in;

    if (i == WINDOW_MAX - 1) begin : g_top
      assign up_valid = 1'b0;
      assign up_value = '0;
      assign up_tag   = '0;
    end else begin : g_mid
      assign up_valid = c_valid[i+1];
      assign up_value = c_value[i+1];
      assign up_tag   = c_tag[i+1];
    end

    if (i == 0) begin : g_bottom
      assign lo_valid = 1'b0;
      assign lo_value = '0;
      assign lo_tag   = '0;
      assign lo_gt    = 1'b0;
      assign del_in   = 1'b0;
    end else begin : g_link
      assign lo_valid = a_valid[i-1];
      assign lo_value = a_value[i-1];
      assign lo_tag   = a_tag[i-1];
      assign lo_gt    = a_gt[i-1];
      assign del_in   = del_c[i-1];
    end

    smac_cell #(
      .TAG_W (TAG_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .old_tag  (oldest_ptr),
      .new_tag  (new_tag),
      .up_valid (up_valid),
      .up_value (up_value),
      .up_tag   (up_tag),
      .lo_valid (lo_valid),
      .lo_value (lo_value),
      .lo_tag   (lo_tag),
      .lo_gt    (lo_gt),
      .del_in   (del_in),
      .valid    (c_valid[i]),
      .value    (c_value[i]),
      .tag      (c_tag[i]),
      .a_valid  (a_valid[i]),
      .a_value  (a_value[i]),
      .a_tag    (a_tag[i]),
      .a_gt     (a_gt[i]),
      .del_out  (del_c[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= smac_pkg::CFG_W'(1);
      fill_level    <= '0;
      oldest_ptr    <= '0;
      alert_counter <= '0;
    end else if (wr_en) begin
      window_length <= wr_data;
      fill_level    <= '0;
      oldest_ptr    <= '0;
      alert_counter <= '0;
    end else if (accept) begin
      if (full) begin
        oldest_ptr    <= ptr_next;
        alert_counter <= counter_next;
        fill_level    <= fill_eff;
      end else begin
        oldest_ptr    <= '0;
        alert_counter <= in_ch.new_series ? '0 : alert_counter;
        fill_level    <= fill_eff + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && full && !wr_en) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && full) begin
      res_alert <= alert;
      res_total <= counter_next;
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.alert       = res_alert;
  assign out_ch.alert_total = res_total;

endmodule

`default_nettype wire

// ===== sv/smac_checker.sv =====
// ---------------------------------------------------------------------------
// smac_checker: port level checks for the sliding median alert block
// Watches the request channels and the length write port of the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module smac_checker (
  input wire                         clk,
  input wire                         rst,
  input wire                         wr_en,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         new_series,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire                         alert,
  input wire [smac_pkg::TOTAL_W-1:0] alert_total
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(alert) && $stable(alert_total))
    else $error("result changed while stalled");

  // every new result comes from a sample taken the cycle before
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without a sample request");

  // a new series restarts the fill, so that sample gives no result
  a_series_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && new_series |=> !$rose(out_valid))
    else $error("result from first sample of a series");

  // a length write restarts the series
  a_cfg_fill: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> !$rose(out_valid))
    else $error("result right after a length write");

  // an alert is counted until the total saturates, so its total is never zero
  a_alert_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && alert |-> alert_total != '0)
    else $error("alert with zero total");

endmodule

bind sliding_median_alert_top smac_checker u_smac_checker (
  .clk         (clk),
  .rst         (rst),
  .wr_en       (wr_en),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .new_series  (in_ch.new_series),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .alert       (out_ch.alert),
  .alert_total (out_ch.alert_total)
);

`default_nettype wire
